>>> rtl/segred_pkg.sv
package segred_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 24;
    localparam int LANE_W  = 3;
    localparam int COUNT_W = 24;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_ARG   = 8'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_SUM  = 2'd0,
        MODE_MEAN = 2'd1,
        MODE_MIN  = 2'd2,
        MODE_MAX  = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic in_valid;
        logic mean_close;
        logic div_done;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic div_start;
        logic div_load;
    } ctrl_cmd_t;

endpackage

>>> rtl/segred_if.sv
interface segred_item_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [segred_pkg::VALUE_W-1:0] value;
    logic [segred_pkg::POS_W-1:0]          element_position;
    logic [segred_pkg::LANE_W-1:0]         lane;
    logic                                 segment_last;
    logic                                 segment_empty;

    modport source (output valid, value, element_position, lane, segment_last, segment_empty,
                    input ready);
    modport sink (input valid, value, element_position, lane, segment_last, segment_empty,
                  output ready);
endinterface

interface segred_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [segred_pkg::VALUE_W-1:0] result_value;
    logic [segred_pkg::POS_W-1:0]          arg_position;
    logic [segred_pkg::LANE_W-1:0]         result_lane;

    modport source (output valid, result_value, arg_position, result_lane, input ready);
    modport sink (input valid, result_value, arg_position, result_lane, output ready);
endinterface

interface segred_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [segred_pkg::CFG_IDX_W-1:0]     index;
    logic [segred_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/segred_ctrl.sv
module segred_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  segred_pkg::dp_status_t status,
    output segred_pkg::ctrl_cmd_t  cmd
);

    segred_pkg::ctrl_state_t state_reg;
    segred_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= segred_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            segred_pkg::ST_IDLE:
            begin
                if (status.out_free && status.in_valid && status.mean_close)
                begin
                    state_next = segred_pkg::ST_DIVIDE;
                end
            end
            segred_pkg::ST_DIVIDE:
            begin
                if (status.div_done && status.out_free)
                begin
                    state_next = segred_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = segred_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            segred_pkg::ST_IDLE:
            begin
                cmd.in_ready  = status.out_free;
                cmd.accept    = status.out_free && status.in_valid;
                cmd.div_start = status.out_free && status.in_valid && status.mean_close;
            end
            segred_pkg::ST_DIVIDE:
            begin
                cmd.div_load = status.div_done && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/segred_dp.sv
module segred_dp #(
    parameter int LANES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    segred_item_if.sink            src,
    segred_result_if.source        res,
    segred_cfg_if.sink             cfg,
    input  segred_pkg::ctrl_cmd_t  cmd,
    output segred_pkg::dp_status_t status
);

    localparam int DEPTH = (LANES < 8) ? LANES : 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NSLOT = 2 ** IDX_W;
    localparam int LCMP_W = 8;

    logic [segred_pkg::MODE_W-1:0]  mode_reg;
    logic [segred_pkg::POS_W-1:0]   empty_arg_reg;

    logic [segred_pkg::VALUE_W-1:0] acc_reg   [0:NSLOT-1];
    logic [segred_pkg::COUNT_W-1:0] count_reg [0:NSLOT-1];
    logic [segred_pkg::POS_W-1:0]   best_reg  [0:NSLOT-1];

    logic                           out_valid_reg;
    logic signed [segred_pkg::VALUE_W-1:0] out_value_reg;
    logic [segred_pkg::POS_W-1:0]   out_arg_reg;
    logic [segred_pkg::LANE_W-1:0]  out_lane_reg;

    logic [segred_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [segred_pkg::VALUE_W-1:0]   div_quo_reg;
    logic [segred_pkg::COUNT_W:0]     div_rem_reg;
    logic [segred_pkg::COUNT_W:0]     div_den_reg;
    logic                             div_neg_reg;
    logic [segred_pkg::LANE_W-1:0]    div_lane_reg;

    logic [IDX_W-1:0]               idx;
    logic                           lane_ok;
    logic                           is_minmax;
    logic [segred_pkg::VALUE_W-1:0] cur_acc;
    logic [segred_pkg::COUNT_W-1:0] cur_count;
    logic [segred_pkg::POS_W-1:0]   cur_best;
    logic [segred_pkg::VALUE_W-1:0] acc_next;
    logic [segred_pkg::COUNT_W-1:0] count_next;
    logic [segred_pkg::POS_W-1:0]   best_next;
    logic                           fire;
    logic                           closes;
    logic                           load_direct;
    logic [segred_pkg::VALUE_W-1:0] direct_value;
    logic [segred_pkg::POS_W-1:0]   direct_arg;
    logic [segred_pkg::VALUE_W-1:0] dvd_mag;
    logic [segred_pkg::COUNT_W:0]   rem_shift;
    logic                           rem_ge;
    logic [segred_pkg::VALUE_W-1:0] div_result;

    assign idx       = src.lane[IDX_W-1:0];
    assign lane_ok   = (LCMP_W'(src.lane) < LCMP_W'(LANES));
    assign is_minmax = (mode_reg == segred_pkg::MODE_MIN) || (mode_reg == segred_pkg::MODE_MAX);
    assign cur_acc   = acc_reg[idx];
    assign cur_count = count_reg[idx];
    assign cur_best  = best_reg[idx];
    assign fire      = cmd.accept && lane_ok;
    assign closes    = src.segment_last || src.segment_empty;

    always_comb
    begin
        acc_next   = cur_acc;
        best_next  = cur_best;
        count_next = cur_count;
        if (cur_count == '0)
        begin
            acc_next  = src.value;
            best_next = src.element_position;
        end
        else
        begin
            case (mode_reg)
                segred_pkg::MODE_MIN:
                begin
                    if ($signed(src.value) < $signed(cur_acc))
                    begin
                        acc_next  = src.value;
                        best_next = src.element_position;
                    end
                end
                segred_pkg::MODE_MAX:
                begin
                    if ($signed(src.value) > $signed(cur_acc))
                    begin
                        acc_next  = src.value;
                        best_next = src.element_position;
                    end
                end
                default:
                begin
                    acc_next = cur_acc + src.value;
                end
            endcase
        end
        if (cur_count != segred_pkg::COUNT_MAX)
        begin
            count_next = cur_count + 1'b1;
        end
    end

    always_comb
    begin
        direct_value = '0;
        direct_arg   = '0;
        if (src.segment_empty)
        begin
            direct_arg = is_minmax ? empty_arg_reg : '0;
        end
        else
        begin
            direct_value = acc_next;
            direct_arg   = is_minmax ? best_next : '0;
        end
    end

    assign load_direct = fire && closes &&
                         !(!src.segment_empty && mode_reg == segred_pkg::MODE_MEAN);

    assign status.in_valid   = src.valid;
    assign status.mean_close = lane_ok && !src.segment_empty && src.segment_last &&
                               (mode_reg == segred_pkg::MODE_MEAN);
    assign status.div_done   = (div_cnt_reg == '0);
    assign status.out_free   = !out_valid_reg || res.ready;

    assign src.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= segred_pkg::MODE_SUM;
            empty_arg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == segred_pkg::CFG_REDUCE_MODE)
            begin
                mode_reg <= cfg.data[segred_pkg::MODE_W-1:0];
            end
            else if (cfg.index == segred_pkg::CFG_EMPTY_ARG)
            begin
                empty_arg_reg <= cfg.data[segred_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                acc_reg[i]   <= '0;
                count_reg[i] <= '0;
                best_reg[i]  <= '0;
            end
        end
        else if (fire)
        begin
            if (closes)
            begin
                acc_reg[idx]   <= '0;
                count_reg[idx] <= '0;
                best_reg[idx]  <= '0;
            end
            else
            begin
                acc_reg[idx]   <= acc_next;
                count_reg[idx] <= count_next;
                best_reg[idx]  <= best_next;
            end
        end
    end

    assign dvd_mag   = acc_next[segred_pkg::VALUE_W-1] ? (~acc_next + 1'b1) : acc_next;
    assign rem_shift = {div_rem_reg[segred_pkg::COUNT_W-1:0], div_quo_reg[segred_pkg::VALUE_W-1]};
    assign rem_ge    = (rem_shift >= div_den_reg);
    assign div_result = div_neg_reg ? (~div_quo_reg + 1'b1) : div_quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start && lane_ok)
        begin
            div_cnt_reg <= segred_pkg::DIV_CNT_W'(segred_pkg::DIV_STEPS);
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start && lane_ok)
        begin
            div_quo_reg  <= dvd_mag;
            div_rem_reg  <= '0;
            div_den_reg  <= {1'b0, count_next};
            div_neg_reg  <= acc_next[segred_pkg::VALUE_W-1];
            div_lane_reg <= src.lane;
        end
        else if (div_cnt_reg != '0)
        begin
            div_quo_reg <= {div_quo_reg[segred_pkg::VALUE_W-2:0], rem_ge};
            div_rem_reg <= rem_ge ? (rem_shift - div_den_reg) : rem_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_direct || cmd.div_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            out_value_reg <= direct_value;
            out_arg_reg   <= direct_arg;
            out_lane_reg  <= src.lane;
        end
        else if (cmd.div_load)
        begin
            out_value_reg <= div_result;
            out_arg_reg   <= '0;
            out_lane_reg  <= div_lane_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.arg_position = out_arg_reg;
    assign res.result_lane  = out_lane_reg;

endmodule

>>> rtl/segment_reduce_csr.sv
// Channel | Direction | Carries
// src     | in        | value, element_position, lane, segment_last, segment_empty
// res     | out       | result_value, arg_position, result_lane
// cfg     | in        | index, data (0 reduce_mode, 1 empty_arg_index)
//
// An accepted item whose lane is below LANES updates its lane's registers when it is taken.
// A closing item in mean mode holds off further input while the serial
// divider produces one quotient bit per cycle; no other item holds off the input.
// The result register frees the input side unless it still holds an untaken item.
// Reset clears the lane registers, the configuration and the result valid flag at once.
module segment_reduce_csr #(
    parameter int LANES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    segred_item_if.sink      src,
    segred_result_if.source  res,
    segred_cfg_if.sink       cfg
);

    segred_pkg::dp_status_t status;
    segred_pkg::ctrl_cmd_t  cmd;

    segred_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    segred_dp #(
        .LANES (LANES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src),
        .res    (res),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

endmodule
